/* sv/trial_division_factoriser_unit_defines.svh */
// assertion macros shared by the checker files of the factoriser
// no dependencies; included by name where assertions are written
`ifndef TRIAL_DIVISION_FACTORISER_UNIT_DEFINES_SVH
`define TRIAL_DIVISION_FACTORISER_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define TDF_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication under reset
`define TDF_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* sv/tdf_pkg.sv */
// shared widths, start constants and divider status type of the factoriser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tdf_pkg;

    localparam int NUMBER_BITS = 16;
    localparam int FACTOR_BITS = 16;
    localparam int EXP_BITS    = 5;

    // first trial divisor and its square
    localparam int FIRST_DIVISOR = 2;
    localparam int FIRST_SQUARE  = 4;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } tdf_div_status_t;

endpackage

`default_nettype wire

/* sv/tdf_if.sv */
// word channels of the factoriser: number in, factor/exponent out
// depends on tdf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tdf_in_if import tdf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface tdf_out_if import tdf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FACTOR_BITS-1:0] factor;
    logic [EXP_BITS-1:0]    exponent;
    logic                   last_factor;
    logic                   invalid;

    modport source (output valid, output factor, output exponent, output last_factor,
                    output invalid, input ready);
    modport sink   (input valid, input factor, input exponent, input last_factor,
                    input invalid, output ready);
endinterface

`default_nettype wire

/* sv/trial_division_factoriser_unit.sv */
// trial division factoriser: one number in, one word per distinct prime factor out
// each divisor is tried by the square check, then the bit-serial divide, and when it does not
// divide, by a step that flushes the exponent and moves on to the next divisor
// throughput: one number at a time, the next is taken once its last word is registered
// reset: rst_n asynchronous active low, clears the sequencer, divider count and output valid
// depends on tdf_pkg, tdf_if, tdf_serial_div
`timescale 1ns / 1ps
`default_nettype none

module trial_division_factoriser_unit import tdf_pkg::*; #(
    parameter int NUMBER_WIDTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tdf_in_if.sink     req,
    tdf_out_if.source  rsp
);

    localparam int W  = NUMBER_WIDTH;
    localparam int SW = NUMBER_WIDTH + 2;          // square overshoots the remainder
    localparam int CW = $clog2(NUMBER_WIDTH + 1);  // exponent can reach the width

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;  // square vs remainder, kicks the divider
    localparam logic [2:0] S_DIV   = 3'd2;  // waiting on the serial divider
    localparam logic [2:0] S_ADV   = 3'd3;  // flush exponent, step divisor
    localparam logic [2:0] S_FINAL = 3'd4;  // leftover handling
    localparam logic [2:0] S_TAIL  = 3'd5;  // leftover as its own factor
    localparam logic [2:0] S_ZERO  = 3'd6;  // input zero, flagged word

    logic [2:0]    state_reg, state_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [SW-1:0] s_reg, s_next;
    logic [CW-1:0] c_reg, c_next;

    // output word register
    logic                   out_valid_reg, out_valid_next;
    logic [FACTOR_BITS-1:0] factor_reg;
    logic [EXP_BITS-1:0]    exponent_reg;
    logic                   last_reg;
    logic                   invalid_reg;

    logic [W-1:0]    num_in;
    logic            slot_free;
    logic            emit_want;
    logic            emit_go;
    logic [W-1:0]    emit_factor;
    logic [CW-1:0]   emit_exp;
    logic            emit_last;
    logic            emit_inv;

    logic            div_start;
    logic [W-1:0]    div_quot;
    tdf_div_status_t div_stat;

    logic            sq_fits;

    assign num_in    = W'(req.number);
    assign req.ready = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign emit_go   = emit_want && slot_free;
    assign sq_fits   = s_reg <= SW'(r_reg);
    assign div_start = (state_reg == S_CHECK) && sq_fits;

    tdf_serial_div #(
        .W (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (r_reg),
        .divisor  (d_reg),
        .quotient (div_quot),
        .status   (div_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        r_next      = r_reg;
        d_next      = d_reg;
        s_next      = s_reg;
        c_next      = c_reg;
        emit_want   = 1'b0;
        emit_factor = d_reg;
        emit_exp    = c_reg;
        emit_last   = 1'b0;
        emit_inv    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    r_next = num_in;
                    d_next = W'(FIRST_DIVISOR);
                    s_next = SW'(FIRST_SQUARE);
                    c_next = '0;
                    state_next = (num_in == '0) ? S_ZERO : S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = sq_fits ? S_DIV : S_FINAL;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.rem_zero)
                    begin
                        // divisor goes in again
                        r_next     = div_quot;
                        c_next     = c_reg + 1'b1;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_ADV:
            begin
                emit_want = (c_reg != '0);
                if (c_reg == '0 || slot_free)
                begin
                    // (d+1)^2 = d^2 + 2d + 1
                    c_next     = '0;
                    d_next     = d_reg + 1'b1;
                    s_next     = s_reg + SW'({d_reg, 1'b1});
                    state_next = S_CHECK;
                end
            end
            S_FINAL:
            begin
                if (r_reg == d_reg)
                begin
                    // leftover is one more power of the divisor
                    emit_want = 1'b1;
                    emit_exp  = c_reg + 1'b1;
                    emit_last = 1'b1;
                    if (slot_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    emit_want = (c_reg != '0);
                    if (c_reg == '0 || slot_free)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                emit_want   = 1'b1;
                emit_factor = r_reg;
                emit_exp    = CW'(1);
                emit_last   = 1'b1;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ZERO:
            begin
                emit_want   = 1'b1;
                emit_factor = '0;
                emit_exp    = '0;
                emit_last   = 1'b1;
                emit_inv    = 1'b1;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register frees as soon as the sink takes the word
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        d_reg <= d_next;
        s_reg <= s_next;
        c_reg <= c_next;
        if (emit_go)
        begin
            factor_reg   <= FACTOR_BITS'(emit_factor);
            exponent_reg <= EXP_BITS'(emit_exp);
            last_reg     <= emit_last;
            invalid_reg  <= emit_inv;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.factor      = factor_reg;
    assign rsp.exponent    = exponent_reg;
    assign rsp.last_factor = last_reg;
    assign rsp.invalid     = invalid_reg;

endmodule

`default_nettype wire

/* sv/tdf_serial_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
// depends on tdf_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdf_serial_div import tdf_pkg::*; #(
    parameter int W = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic      [W-1:0] quotient,
    output tdf_div_status_t   status
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     p_reg, p_next;
    logic [W-1:0]     q_reg, q_next;
    logic [W-1:0]     d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       fits;

    always_comb
    begin
        shifted   = {p_reg, q_reg[W-1]};
        fits      = shifted >= {1'b0, d_reg};
        diff      = shifted - {1'b0, d_reg};
        p_next    = p_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            p_next   = '0;
            q_next   = dividend;
            d_next   = divisor;
            cnt_next = CNT_W'(W);
        end
        else if (cnt_reg != '0)
        begin
            p_next    = fits ? diff[W-1:0] : shifted[W-1:0];
            q_next    = {q_reg[W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    assign quotient        = q_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (p_reg == '0);

endmodule

`default_nettype wire

/* sv/tdf_checker.sv */
// port-level checks on the factoriser, bound to the top level
// depends on tdf_pkg, tdf_if and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "trial_division_factoriser_unit_defines.svh"

module tdf_checker import tdf_pkg::*; (
    input wire logic  clk,
    input wire logic  rst_n,
    tdf_in_if.sink    req,
    tdf_out_if.source rsp
);

    // a stalled word holds
    `TDF_ASSERT_NEXT(a_out_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.factor) && $stable(rsp.exponent) && $stable(rsp.last_factor), "output word changed while stalled")

    // the invalid word for a zero input carries factor zero, exponent zero and last set
    `TDF_ASSERT_NOW(a_invalid_shape, clk, rst_n, rsp.valid && rsp.invalid, rsp.factor == '0 && rsp.exponent == '0 && rsp.last_factor, "malformed invalid word")

    // a real factor always has a power
    `TDF_ASSERT_NOW(a_exp_nonzero, clk, rst_n, rsp.valid && !rsp.invalid, rsp.exponent != '0 && rsp.factor != '0, "factor word without exponent")

    // one number at a time
    `TDF_ASSERT_NEXT(a_busy_after_take, clk, rst_n, req.valid && req.ready, !req.ready, "new number taken while busy")

endmodule

bind trial_division_factoriser_unit tdf_checker u_tdf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

`default_nettype wire

/* verif/tb.sv */
// testbench for trial_division_factoriser_unit: directed and random numbers,
// each factor word checked against a behavioral trial-division predictor
// depends on tdf_pkg, tdf_if and the factoriser rtl
`timescale 1ns / 1ps

module tb;
    import tdf_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int RANDOM_ITEMS  = 124;
    localparam int DRAIN_EVERY   = 40;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_WAIT      = 17;

    // one expected factor word plus the number it came from, for messages
    typedef struct {
        logic [NUMBER_BITS-1:0] number;
        logic [FACTOR_BITS-1:0] factor;
        logic [EXP_BITS-1:0]    exponent;
        logic                   last_factor;
        logic                   invalid;
    } factor_word_t;

    logic clk = 1'b0;
    logic rst_n;

    tdf_in_if  req_if ();
    tdf_out_if rsp_if ();

    trial_division_factoriser_unit #(
        .NUMBER_WIDTH (NUMBER_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    factor_word_t expected_factors[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           req_burst;
    int           rsp_burst = 0;

    // predictor copy of the factoriser state, left by the last number
    logic [NUMBER_BITS-1:0] last_remainder;
    logic [NUMBER_BITS-1:0] last_divisor;
    logic [17:0]            last_square;
    logic [EXP_BITS-1:0]    last_exponent;

    always #2 clk = ~clk;

    // global cycle count, kills the run if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // idle draw shared by both sides: mostly a random wait up to MAX_WAIT, sometimes a run of
    // back-to-back words with no idling at all
    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void push_factor(input logic [NUMBER_BITS-1:0] number,
                                        input logic [NUMBER_BITS-1:0] factor,
                                        input logic [EXP_BITS-1:0]    exponent,
                                        input logic                   last_factor,
                                        input logic                   invalid);
        factor_word_t word;
        word.number      = number;
        word.factor      = factor;
        word.exponent    = exponent;
        word.last_factor = last_factor;
        word.invalid     = invalid;
        expected_factors.push_back(word);
    endfunction

    // trial division: divisor from 2, square tracked by adding 2d+1, stop once
    // the square passes the remainder; leftover is one more factor, merged with
    // the divisor when the two are equal
    function automatic void predict_factors(input logic [NUMBER_BITS-1:0] number);
        logic [NUMBER_BITS-1:0] remainder;
        logic [NUMBER_BITS-1:0] divisor;
        logic [17:0]            square;
        logic [EXP_BITS-1:0]    count;
        remainder = number;
        divisor   = NUMBER_BITS'(FIRST_DIVISOR);
        square    = 18'(FIRST_SQUARE);
        count     = '0;

        // zero has no factorization: one invalid word, state cleared
        if (remainder == '0)
        begin
            last_remainder = '0;
            last_divisor   = '0;
            last_square    = '0;
            last_exponent  = '0;
            push_factor(number, '0, '0, 1'b1, 1'b1);
            return;
        end

        while (square <= {2'b00, remainder})
        begin
            if (remainder % divisor == '0)
            begin
                remainder = remainder / divisor;
                count     = count + 1'b1;
            end
            else
            begin
                if (count != '0)
                    push_factor(number, divisor, count, 1'b0, 1'b0);
                count   = '0;
                divisor = divisor + 1'b1;
                square  = square + {1'b0, divisor, 1'b0} - 18'd1;
            end
        end

        if (remainder == divisor)
        begin
            count = count + 1'b1;
            push_factor(number, divisor, count, 1'b1, 1'b0);
        end
        else
        begin
            if (count != '0)
                push_factor(number, divisor, count, 1'b0, 1'b0);
            // leftover is prime, or 1 for input one
            push_factor(number, remainder, EXP_BITS'(1), 1'b1, 1'b0);
        end

        last_remainder = remainder;
        last_divisor   = divisor;
        last_square    = square;
        last_exponent  = count;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // result side: compare every accepted word with the oldest expectation
    always @(posedge clk)
    begin
        factor_word_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_factors.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word factor=%0d exponent=%0d",
                                          rsp_if.factor, rsp_if.exponent));
            end
            else
            begin
                want = expected_factors.pop_front();
                if (rsp_if.factor !== want.factor)
                    report_mismatch($sformatf("number %0d: factor %0d, expected %0d",
                                              want.number, rsp_if.factor, want.factor));
                if (rsp_if.exponent !== want.exponent)
                    report_mismatch($sformatf("number %0d factor %0d: exponent %0d, expected %0d",
                                              want.number, want.factor, rsp_if.exponent,
                                              want.exponent));
                if (rsp_if.last_factor !== want.last_factor)
                    report_mismatch($sformatf("number %0d factor %0d: last_factor %0b, expected %0b",
                                              want.number, want.factor, rsp_if.last_factor,
                                              want.last_factor));
                if (rsp_if.invalid !== want.invalid)
                    report_mismatch($sformatf("number %0d: invalid %0b, expected %0b",
                                              want.number, rsp_if.invalid, want.invalid));
            end
        end
    end

    // result side ready: random stall before each word, held high otherwise
    initial
    begin
        int stall;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(rsp_burst);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid && rsp_if.ready));
            @(negedge clk);
        end
    end

    // send one number; called at a falling edge, returns at a falling edge
    // with valid still high so a gapless next word needs no re-raise
    task automatic send_number(input logic [NUMBER_BITS-1:0] number);
        int gap;
        gap = draw_wait(req_burst);
        if (gap > 0)
        begin
            // junk on the data lines while valid is low
            req_if.valid  <= 1'b0;
            req_if.number <= NUMBER_BITS'($urandom);
            repeat (gap) @(negedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.number <= number;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_factors(number);
        @(negedge clk);
    endtask

    // hold off the input until every expected word has come back
    task automatic drain_factors();
        req_if.valid <= 1'b0;
        while (expected_factors.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int small_prime(input int index);
        case (index)
            0:       return 2;
            1:       return 3;
            2:       return 5;
            3:       return 7;
            4:       return 11;
            5:       return 13;
            6:       return 17;
            7:       return 19;
            8:       return 23;
            9:       return 29;
            default: return 31;
        endcase
    endfunction

    // mix of plain random numbers, smooth numbers with many distinct factors,
    // prime powers and small values (zero and one among them)
    function automatic logic [NUMBER_BITS-1:0] draw_number();
        int kind;
        int value;
        int prime;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
            return NUMBER_BITS'($urandom_range(0, 65535));
        if (kind <= 7)
        begin
            value = 1;
            repeat ($urandom_range(1, 8))
            begin
                prime = small_prime($urandom_range(0, 10));
                if (value * prime <= 65535)
                    value = value * prime;
            end
            return NUMBER_BITS'(value);
        end
        if (kind == 8)
        begin
            prime = small_prime($urandom_range(0, 10));
            value = prime;
            while (value * prime <= 65535 && $urandom_range(0, 3) != 0)
                value = value * prime;
            return NUMBER_BITS'(value);
        end
        return NUMBER_BITS'($urandom_range(0, 300));
    endfunction

    // zero, one, smallest primes, and leftovers that merge with the divisor
    task automatic test_special_cases();
        send_number(16'd0);
        send_number(16'd1);
        send_number(16'd0);
        send_number(16'd2);
        send_number(16'd3);
        send_number(16'd4);
        send_number(16'd8);
        send_number(16'd49);
        send_number(16'd1);
    endtask

    // all-ones and alternating patterns, the largest prime, the deepest power
    // of two, the smallest number with six distinct factors and the square of 255
    task automatic test_extreme_numbers();
        send_number(16'hFFFF);
        send_number(16'hFFFE);
        send_number(16'd65521);
        send_number(16'h8000);
        send_number(16'h7FFF);
        send_number(16'hAAAA);
        send_number(16'h5555);
        send_number(16'd30030);
        send_number(16'd65025);
        drain_factors();
    endtask

    // random numbers, with a full drain of the results now and then
    task automatic test_random_numbers(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_number(draw_number());
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_factors();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.number  = '0;
        req_burst      = 0;
        last_remainder = '0;
        last_divisor   = '0;
        last_square    = '0;
        last_exponent  = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_special_cases();
        test_extreme_numbers();
        test_random_numbers(RANDOM_ITEMS);

        // everything sent: wait out the last words, then watch for strays
        drain_factors();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* trial_division_factoriser_unit.f */
+incdir+sv
sv/tdf_pkg.sv
sv/tdf_if.sv
sv/tdf_serial_div.sv
sv/trial_division_factoriser_unit.sv
sv/tdf_checker.sv
verif/tb.sv
